// ===== design/rmbv_pkg.sv =====
// ----------------------------------------------------------------------------
// rmbv_pkg
// Shared constants, types and helpers for the rotation-between-vectors block.
// ----------------------------------------------------------------------------
package rmbv_pkg;

  // fixed point format
  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);

  // internal widths
  localparam int PROD_W = 2 * IN_W;     // 16x16 product
  localparam int SUM_W  = PROD_W + 2;   // sum of three products
  localparam int V_W    = 19;           // rounded cross / dot
  localparam int DEN_W  = 18;           // positive denominator
  localparam int SQ_W   = 2 * V_W;      // entries of K*K
  localparam int QW     = 21;           // quotient bits kept before clamping
  localparam int REM_W  = DEN_W;
  localparam int NHI_W  = SQ_W - QW;    // numerator bits above the quotient
  localparam int ACC_W  = 24;           // I + K + quotient
  localparam int OUT_W  = 16;

  // pipeline shape
  localparam int STEPS      = 3;                 // quotient bits per stage
  localparam int DIV_STAGES = QW / STEPS;
  localparam int NSTG       = 5 + DIV_STAGES + 1;

  // config register map
  localparam logic REG_MIN_DEN = 1'b0;

  typedef logic signed [V_W-1:0] vcomp_t;

  typedef struct packed {
    logic signed [IN_W-1:0] src_x;
    logic signed [IN_W-1:0] src_y;
    logic signed [IN_W-1:0] src_z;
    logic signed [IN_W-1:0] dst_x;
    logic signed [IN_W-1:0] dst_y;
    logic signed [IN_W-1:0] dst_z;
  } vec_t;

  typedef struct packed {
    vcomp_t             vx;
    vcomp_t             vy;
    vcomp_t             vz;
    logic [DEN_W-1:0]   den;
    logic               degen;
  } front_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [REM_W-1:0] rem;
    logic [QW-1:0]    nlo;
    logic [QW-1:0]    q;
  } div_elem_t;

  typedef struct packed {
    div_elem_t [8:0]  el;
    vcomp_t           vx;
    vcomp_t           vy;
    vcomp_t           vz;
    logic [DEN_W-1:0] den;
    logic             degen;
  } div_word_t;

  typedef struct packed {
    logic signed [8:0][OUT_W-1:0] r;
    logic                         degen;
  } rot_t;

  // drop FRAC_BITS fraction bits, nearest, ties away from zero
  function automatic vcomp_t round_frac(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] q;
    begin
      mag = x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
      q   = (mag + SUM_W'(HALF)) >> FRAC_BITS;
      return x[SUM_W-1] ? V_W'(-q) : V_W'(q);
    end
  endfunction

  // entry of the skew matrix [v]x at row-major position idx
  function automatic vcomp_t skew(input logic [3:0] idx, input vcomp_t vx,
                                 input vcomp_t vy, input vcomp_t vz);
    begin
      case (idx)
        4'd1:    return -vz;
        4'd2:    return vy;
        4'd3:    return vz;
        4'd5:    return -vx;
        4'd6:    return -vy;
        4'd7:    return vx;
        default: return '0;
      endcase
    end
  endfunction

endpackage

// ===== design/rmbv_if.sv =====
// ----------------------------------------------------------------------------
// rmbv_if
// Valid/ready channels: vector pair in, rotation matrix out.
// ----------------------------------------------------------------------------
interface rmbv_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  src_x;
  logic signed [15:0]  src_y;
  logic signed [15:0]  src_z;
  logic signed [15:0]  dst_x;
  logic signed [15:0]  dst_y;
  logic signed [15:0]  dst_z;
  modport source (output valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, input ready);
  modport sink   (input valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, output ready);
endinterface

interface rmbv_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  r00;
  logic signed [15:0]  r01;
  logic signed [15:0]  r02;
  logic signed [15:0]  r10;
  logic signed [15:0]  r11;
  logic signed [15:0]  r12;
  logic signed [15:0]  r20;
  logic signed [15:0]  r21;
  logic signed [15:0]  r22;
  logic                degenerate;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, degenerate,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, degenerate,
                  output ready);
endinterface

// ===== design/rmbv_front.sv =====
// ----------------------------------------------------------------------------
// rmbv_front
// Stages 1-3: products, cross/dot sums, rounding, denominator and flag.
// ----------------------------------------------------------------------------
module rmbv_front import rmbv_pkg::*; (
  input  logic        clk,
  input  logic [2:0]  en,
  input  vec_t        vin,
  input  logic [15:0] min_den,
  output front_t      fout
);

  logic signed [PROD_W-1:0] p [9];
  logic signed [SUM_W-1:0]  c0, c1, c2, d;
  logic signed [SUM_W-1:0]  dot;
  logic signed [V_W:0]      den_s;

  // stage 1: the nine products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p[0] <= vin.src_y * vin.dst_z;
      p[1] <= vin.src_z * vin.dst_y;
      p[2] <= vin.src_z * vin.dst_x;
      p[3] <= vin.src_x * vin.dst_z;
      p[4] <= vin.src_x * vin.dst_y;
      p[5] <= vin.src_y * vin.dst_x;
      p[6] <= vin.src_x * vin.dst_x;
      p[7] <= vin.src_y * vin.dst_y;
      p[8] <= vin.src_z * vin.dst_z;
    end
  end

  // stage 2: cross and dot sums
  always_ff @(posedge clk) begin
    if (en[1]) begin
      c0 <= SUM_W'(p[0]) - SUM_W'(p[1]);
      c1 <= SUM_W'(p[2]) - SUM_W'(p[3]);
      c2 <= SUM_W'(p[4]) - SUM_W'(p[5]);
      d  <= SUM_W'(p[6]) + SUM_W'(p[7]) + SUM_W'(p[8]);
    end
  end

  // stage 3: round, denominator, degenerate test
  assign dot   = SUM_W'(round_frac(d));
  assign den_s = (V_W+1)'(dot) + (V_W+1)'(ONE);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      fout.vx    <= round_frac(c0);
      fout.vy    <= round_frac(c1);
      fout.vz    <= round_frac(c2);
      fout.den   <= DEN_W'(den_s);
      fout.degen <= (den_s <= 0) || (den_s < $signed({4'b0, min_den}));
    end
  end

endmodule

// ===== design/rmbv_sqr.sv =====
// ----------------------------------------------------------------------------
// rmbv_sqr
// Stages 4-5: K*K = v v^T - |v|^2 I, then numerators prepared for division.
// ----------------------------------------------------------------------------
module rmbv_sqr import rmbv_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  front_t     fin,
  output div_word_t  dout
);

  logic signed [SQ_W-1:0] xx, yy, zz, xy, xz, yz;
  front_t                 f4;
  logic signed [SQ_W-1:0] sq [9];
  logic [SQ_W-1:0]        mag [9];
  logic [SQ_W-1:0]        num [9];

  // stage 4: products of v
  always_ff @(posedge clk) begin
    if (en[0]) begin
      xx <= fin.vx * fin.vx;
      yy <= fin.vy * fin.vy;
      zz <= fin.vz * fin.vz;
      xy <= fin.vx * fin.vy;
      xz <= fin.vx * fin.vz;
      yz <= fin.vy * fin.vz;
      f4 <= fin;
    end
  end

  // stage 5: entries, magnitude plus half divisor, quotient range check
  always_comb begin
    sq[0] = -(yy + zz);
    sq[1] = xy;
    sq[2] = xz;
    sq[3] = xy;
    sq[4] = -(xx + zz);
    sq[5] = yz;
    sq[6] = xz;
    sq[7] = yz;
    sq[8] = -(xx + yy);
    for (int e = 0; e < 9; e++) begin
      mag[e] = sq[e][SQ_W-1] ? SQ_W'(-sq[e]) : SQ_W'(sq[e]);
      num[e] = mag[e] + SQ_W'(f4.den >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int e = 0; e < 9; e++) begin
        dout.el[e].neg <= sq[e][SQ_W-1];
        dout.el[e].ovf <= REM_W'(num[e][SQ_W-1:QW]) >= f4.den;
        dout.el[e].rem <= (REM_W'(num[e][SQ_W-1:QW]) >= f4.den) ? '0
                                                                : REM_W'(num[e][SQ_W-1:QW]);
        dout.el[e].nlo <= num[e][QW-1:0];
        dout.el[e].q   <= '0;
      end
      dout.vx    <= f4.vx;
      dout.vy    <= f4.vy;
      dout.vz    <= f4.vz;
      dout.den   <= f4.den;
      dout.degen <= f4.degen;
    end
  end

endmodule

// ===== design/rmbv_div_stage.sv =====
// ----------------------------------------------------------------------------
// rmbv_div_stage
// One stage of the restoring divider: a few quotient bits for all nine entries.
// ----------------------------------------------------------------------------
module rmbv_div_stage import rmbv_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  div_word_t din,
  output div_word_t dout
);

  div_word_t        nxt;
  logic [REM_W:0]   r;

  // shift in numerator bits, subtract where the divisor fits
  always_comb begin
    nxt = din;
    r   = '0;
    for (int e = 0; e < 9; e++) begin
      for (int s = 0; s < STEPS; s++) begin
        r = {nxt.el[e].rem, nxt.el[e].nlo[QW-1]};
        nxt.el[e].nlo = nxt.el[e].nlo << 1;
        if (r >= {1'b0, din.den}) begin
          nxt.el[e].rem = REM_W'(r - {1'b0, din.den});
          nxt.el[e].q   = {nxt.el[e].q[QW-2:0], 1'b1};
        end else begin
          nxt.el[e].rem = REM_W'(r);
          nxt.el[e].q   = {nxt.el[e].q[QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ===== design/rmbv_out_stage.sv =====
// ----------------------------------------------------------------------------
// rmbv_out_stage
// Last stage: I + K + quotient, saturation, degenerate zeroing, output register.
// ----------------------------------------------------------------------------
module rmbv_out_stage import rmbv_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  div_word_t din,
  output rot_t      rout
);

  logic [QW-1:0]           qs  [9];
  logic signed [ACC_W-1:0] qv  [9];
  logic signed [ACC_W-1:0] acc [9];
  rot_t                    nxt;

  always_comb begin
    nxt.degen = din.degen;
    for (int e = 0; e < 9; e++) begin
      // quotients too large to matter saturate the element anyway
      qs[e]  = din.el[e].ovf ? '1 : din.el[e].q;
      qv[e]  = din.el[e].neg ? -ACC_W'(qs[e]) : ACC_W'(qs[e]);
      acc[e] = qv[e] + ACC_W'(skew(4'(e), din.vx, din.vy, din.vz))
               + ((e % 4 == 0) ? ACC_W'(ONE) : ACC_W'(0));
      if (din.degen) begin
        nxt.r[e] = '0;
      end else if (acc[e] > ACC_W'(32767)) begin
        nxt.r[e] = OUT_W'(32767);
      end else if (acc[e] < -ACC_W'(32768)) begin
        nxt.r[e] = OUT_W'(-32768);
      end else begin
        nxt.r[e] = OUT_W'(acc[e]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rout <= nxt;
    end
  end

endmodule

// ===== design/rotation_matrix_between_vectors.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_between_vectors
// Rodrigues rotation matrix turning a source unit vector onto a target one.
// ----------------------------------------------------------------------------
// Input channel vec carries one pair of Q1.14 vectors per beat; output channel
// rot carries the nine Q1.14 matrix entries, row then column, and a degenerate
// flag (set, matrix zero, when 1 + s.t is not above zero or is below min_denominator).
// The APB port holds min_denominator at byte address 0 (reset value 16); write
// it only while no beat is in flight.
// Throughput: one beat per cycle while rot.ready is high. The pipeline depth
// comes from the 21-bit quotient, three bits per stage over seven divider stages,
// plus products and rounding. Every stage carries a valid bit and loads when it
// is empty or its successor moves, so a stalled receiver holds the result while
// bubbles behind it close up; vec.ready drops only once every stage holds a beat.
// Reset clears all valid bits and restores min_denominator.
// ----------------------------------------------------------------------------
module rotation_matrix_between_vectors import rmbv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rmbv_in_if.sink     vec,
  rmbv_out_if.source  rot
);

  logic [15:0]     min_den;
  logic [NSTG-1:0] vld, vld_next, en;
  vec_t            vin;
  front_t          fr;
  div_word_t       dw [DIV_STAGES+1];
  rot_t            res;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_DEN) ? {16'b0, min_den} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_den <= 16'd16;
    end else if (psel && penable && pwrite && paddr[2] == REG_MIN_DEN) begin
      min_den <= pwdata[15:0];
    end
  end

  // stage enables and valid bits
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || rot.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
    vld_next = vld;
    for (int i = 0; i < NSTG; i++) begin
      if (en[i]) begin
        vld_next[i] = (i == 0) ? vec.valid : vld[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign vec.ready = en[0];

  // datapath
  assign vin = '{src_x: vec.src_x, src_y: vec.src_y, src_z: vec.src_z,
                 dst_x: vec.dst_x, dst_y: vec.dst_y, dst_z: vec.dst_z};

  rmbv_front u_front (
    .clk     (clk),
    .en      (en[2:0]),
    .vin     (vin),
    .min_den (min_den),
    .fout    (fr)
  );

  rmbv_sqr u_sqr (
    .clk  (clk),
    .en   (en[4:3]),
    .fin  (fr),
    .dout (dw[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    rmbv_div_stage u_div (
      .clk  (clk),
      .en   (en[5+k]),
      .din  (dw[k]),
      .dout (dw[k+1])
    );
  end

  rmbv_out_stage u_out (
    .clk  (clk),
    .en   (en[NSTG-1]),
    .din  (dw[DIV_STAGES]),
    .rout (res)
  );

  // result beat
  assign rot.valid      = vld[NSTG-1];
  assign rot.r00        = res.r[0];
  assign rot.r01        = res.r[1];
  assign rot.r02        = res.r[2];
  assign rot.r10        = res.r[3];
  assign rot.r11        = res.r[4];
  assign rot.r12        = res.r[5];
  assign rot.r20        = res.r[6];
  assign rot.r21        = res.r[7];
  assign rot.r22        = res.r[8];
  assign rot.degenerate = res.degen;

endmodule

// ===== design/rmbv_checker.sv =====
// ----------------------------------------------------------------------------
// rmbv_assertions
// Port-level checks on the rotation block, bound to the top level.
// ----------------------------------------------------------------------------
module rmbv_assertions (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
  input logic        degenerate
);

  // a degenerate beat carries an all-zero matrix
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> r00 == 0 && r01 == 0 && r02 == 0 && r10 == 0 &&
      r11 == 0 && r12 == 0 && r20 == 0 && r21 == 0 && r22 == 0)
    else $error("degenerate result with non-zero matrix");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // with the output stage empty, the pipeline must take a beat
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output empty");

  // a stalled result holds its valid, diagonal entries and degenerate flag
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(r00) && $stable(r11) &&
      $stable(r22) && $stable(degenerate))
    else $error("stalled result changed");

endmodule

bind rotation_matrix_between_vectors rmbv_assertions u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (vec.ready),
  .out_valid  (rot.valid),
  .out_ready  (rot.ready),
  .r00        (rot.r00),
  .r01        (rot.r01),
  .r02        (rot.r02),
  .r10        (rot.r10),
  .r11        (rot.r11),
  .r12        (rot.r12),
  .r20        (rot.r20),
  .r21        (rot.r21),
  .r22        (rot.r22),
  .degenerate (rot.degenerate)
);
